// ----- rtl/core/cmrq_pkg.sv -----
package cmrq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CAP_W   = 7;
  localparam int LIM_W   = 32;
  localparam int OP_W    = 2;
  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int PAY_W   = 64;
  localparam int TS_W    = 32;
  localparam int NOW_W   = 32;
  localparam int STAT_W  = 2;
  localparam int DISC_W  = 7;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NOCAP = 2'd2
  } status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_LATENCY  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [TS_W-1:0]  ts;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/core/cmrq_ram.sv -----
module cmrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/can_message_ring_queue_unit.sv -----
// Ring queue of CAN messages, oldest entries overwritten when full.
// Input channel (in_valid / in_stall) carries one op per beat: enqueue,
// dequeue (skipping stale entries) or peek. Every op gives exactly one
// result beat on the output channel (out_valid / out_stall).
// Timing: enqueue and empty/invalid ops answer in the cycle after acceptance;
// peek reads the entry RAM, then registers the entry in ST_PEEK; dequeue
// reads it, then in ST_DEQ registers the entry or skips a stale one and
// reads the next, answering empty with no further read once every entry
// is stale. Each step costs one registered read of the single entry RAM.
// Throughput: one op in flight; enqueue sustains 1 beat per cycle while no
// result beat is stalled; peek and dequeue hold off new ops until answered.
// Registers via APB: capacity at 0x0 (write clears both pointers) and
// latency_limit at 0x4. Write them only while the queue is idle.
// Reset: pointers cleared, capacity 64, latency_limit 0; RAM contents are
// not cleared, and no read reaches an unwritten entry.
// Receiver stall: a result beat holds in the output register; in_stall is
// high while a held beat is stalled or an op is in progress.
module can_message_ring_queue_unit #(
  parameter int DEPTH = cmrq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmrq_pkg::PADDR_W-1:0]  paddr,
  input  logic [cmrq_pkg::PDATA_W-1:0]  pwdata,
  output logic [cmrq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cmrq_pkg::OP_W-1:0]     opcode,
  input  logic [cmrq_pkg::ID_W-1:0]     msg_id,
  input  logic [cmrq_pkg::LEN_W-1:0]    msg_len,
  input  logic [cmrq_pkg::PAY_W-1:0]    msg_payload,
  input  logic [cmrq_pkg::TS_W-1:0]     msg_timestamp,
  input  logic [cmrq_pkg::NOW_W-1:0]    now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cmrq_pkg::STAT_W-1:0]   status,
  output logic [cmrq_pkg::ID_W-1:0]     out_id,
  output logic [cmrq_pkg::LEN_W-1:0]    out_len,
  output logic [cmrq_pkg::PAY_W-1:0]    out_payload,
  output logic [cmrq_pkg::TS_W-1:0]     out_timestamp,
  output logic [cmrq_pkg::DISC_W-1:0]   discarded
);

  localparam int CW = cmrq_pkg::CAP_W;
  localparam int AW = $clog2(DEPTH);
  localparam int EW = cmrq_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PEEK = 3'b010,
    ST_DEQ  = 3'b100
  } state_t;

  state_t                         state;
  logic [CW-1:0]                  capacity;
  logic [cmrq_pkg::LIM_W-1:0]     latency_limit;
  logic [CW-1:0]                  read_ptr;
  logic [CW-1:0]                  write_ptr;
  logic [cmrq_pkg::NOW_W-1:0]     now_q;
  logic [cmrq_pkg::DISC_W-1:0]    dropped;
  cmrq_pkg::status_t              out_status;
  cmrq_pkg::entry_t               out_entry;
  logic [cmrq_pkg::DISC_W-1:0]    out_disc;

  logic [CW-1:0]                  cap;
  logic                           out_free;
  logic                           in_accept;
  logic                           cfg_we;
  cmrq_pkg::reg_idx_t             reg_idx;
  logic                           has_data;
  logic [CW-1:0]                  rp_adv;
  logic [CW-1:0]                  wp_adv;
  logic [CW-1:0]                  enq_wp_base;
  logic [CW-1:0]                  read_ptr_next;
  logic [CW-1:0]                  write_ptr_next;
  logic [CW:0]                    fill_before;
  logic [CW:0]                    fill_after;
  logic [cmrq_pkg::DISC_W-1:0]    enq_disc;
  logic                           stale;
  logic [cmrq_pkg::TS_W-1:0]      age;
  logic                           ram_we;
  logic                           ram_re;
  logic [EW-1:0]                  ram_rdata;
  cmrq_pkg::entry_t               rd_entry;
  cmrq_pkg::entry_t               wr_entry;

  function automatic logic [CW:0] fill(input logic [CW-1:0] wp, input logic [CW-1:0] rp,
                                       input logic [CW-1:0] c);
    logic [CW:0] sum;
    sum = {1'b0, wp} + {1'b0, c} - {1'b0, rp};
    if (wp >= rp) begin
      return {1'b0, wp} - {1'b0, rp};
    end
    return sum;
  endfunction

  assign cap      = (int'(capacity) > DEPTH) ? CW'(DEPTH) : capacity;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign has_data = (cap != '0) && (read_ptr != write_ptr) && (int'(read_ptr) < DEPTH);

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = cmrq_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (reg_idx)
      cmrq_pkg::REG_CAPACITY: prdata = cmrq_pkg::PDATA_W'(capacity);
      cmrq_pkg::REG_LATENCY:  prdata = latency_limit;
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    rp_adv = read_ptr + 1'b1;
    wp_adv = write_ptr;
    if ({1'b0, read_ptr} + 1'b1 >= {1'b0, cap}) begin
      rp_adv = '0;
      if (write_ptr >= cap) begin
        wp_adv = '0;
      end
    end
  end

  // enqueue: wrap write pointer, push read pointer past overwritten entries
  always_comb begin
    fill_before = fill(write_ptr, read_ptr, cap);
    enq_wp_base = (write_ptr >= cap) ? '0 : write_ptr;
    if ((write_ptr >= cap) && (read_ptr == '0)) begin
      read_ptr_next = (cap > CW'(2)) ? CW'(2) : '0;
    end else if ({1'b0, read_ptr} == {1'b0, enq_wp_base} + 1'b1) begin
      read_ptr_next = ({1'b0, read_ptr} + 1'b1 >= {1'b0, cap}) ? '0 : read_ptr + 1'b1;
    end else begin
      read_ptr_next = read_ptr;
    end
    write_ptr_next = enq_wp_base + 1'b1;
    fill_after = fill(write_ptr_next, read_ptr_next, cap);
    if (fill_before + 1'b1 >= fill_after) begin
      enq_disc = cmrq_pkg::DISC_W'(fill_before + 1'b1 - fill_after);
    end else begin
      enq_disc = '0;
    end
  end

  assign rd_entry = cmrq_pkg::entry_t'(ram_rdata);
  assign age      = now_q - rd_entry.ts;
  assign stale    = (latency_limit != '0) && (age > latency_limit);

  always_comb begin
    wr_entry.len     = msg_len;
    wr_entry.id      = msg_id;
    wr_entry.payload = msg_payload;
    wr_entry.ts      = msg_timestamp;
  end

  assign ram_we = in_accept && (opcode == cmrq_pkg::OP_ENQ) && (cap != '0);
  assign ram_re = (in_accept && has_data &&
                   (opcode == cmrq_pkg::OP_DEQ || opcode == cmrq_pkg::OP_PEEK)) ||
                  ((state == ST_DEQ) && out_free && stale && has_data);

  cmrq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(enq_wp_base)),
    .wdata (EW'(wr_entry)),
    .re    (ram_re),
    .raddr (AW'(read_ptr)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      read_ptr      <= '0;
      write_ptr     <= '0;
      capacity      <= cmrq_pkg::CAP_RESET;
      latency_limit <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            now_q   <= now_ms;
            dropped <= '0;
            case (cmrq_pkg::op_t'(opcode))
              cmrq_pkg::OP_ENQ: begin
                out_valid <= 1'b1;
                out_entry <= '0;
                if (cap == '0) begin
                  out_status <= cmrq_pkg::STAT_NOCAP;
                  out_disc   <= '0;
                end else begin
                  out_status <= cmrq_pkg::STAT_OK;
                  out_disc   <= enq_disc;
                  read_ptr   <= read_ptr_next;
                  write_ptr  <= write_ptr_next;
                end
              end
              cmrq_pkg::OP_DEQ: begin
                if (has_data) begin
                  read_ptr  <= rp_adv;
                  write_ptr <= wp_adv;
                  state     <= ST_DEQ;
                end else begin
                  out_valid  <= 1'b1;
                  out_status <= cmrq_pkg::STAT_EMPTY;
                  out_entry  <= '0;
                  out_disc   <= '0;
                end
              end
              cmrq_pkg::OP_PEEK: begin
                if (has_data) begin
                  state <= ST_PEEK;
                end else begin
                  out_valid  <= 1'b1;
                  out_status <= cmrq_pkg::STAT_EMPTY;
                  out_entry  <= '0;
                  out_disc   <= '0;
                end
              end
              default: begin
                out_valid  <= 1'b1;
                out_status <= cmrq_pkg::STAT_EMPTY;
                out_entry  <= '0;
                out_disc   <= '0;
              end
            endcase
          end
        end
        ST_PEEK: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= cmrq_pkg::STAT_OK;
            out_entry  <= rd_entry;
            out_disc   <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_DEQ: begin
          if (out_free) begin
            if (!stale) begin
              out_valid  <= 1'b1;
              out_status <= cmrq_pkg::STAT_OK;
              out_entry  <= rd_entry;
              out_disc   <= dropped;
              state      <= ST_IDLE;
            end else if (has_data) begin
              read_ptr  <= rp_adv;
              write_ptr <= wp_adv;
              dropped   <= dropped + 1'b1;
            end else begin
              out_valid  <= 1'b1;
              out_status <= cmrq_pkg::STAT_EMPTY;
              out_entry  <= '0;
              out_disc   <= dropped + 1'b1;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (reg_idx)
          cmrq_pkg::REG_CAPACITY: begin
            capacity  <= pwdata[CW-1:0];
            read_ptr  <= '0;
            write_ptr <= '0;
          end
          cmrq_pkg::REG_LATENCY: latency_limit <= pwdata[cmrq_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign status        = out_status;
  assign out_id        = out_entry.id;
  assign out_len       = out_entry.len;
  assign out_payload   = out_entry.payload;
  assign out_timestamp = out_entry.ts;
  assign discarded     = out_disc;

endmodule

// ----- rtl/core/cmrq_chk.sv -----
module cmrq_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cmrq_pkg::STAT_W-1:0]   status,
  input logic [cmrq_pkg::ID_W-1:0]     out_id,
  input logic [cmrq_pkg::LEN_W-1:0]    out_len,
  input logic [cmrq_pkg::PAY_W-1:0]    out_payload,
  input logic [cmrq_pkg::DISC_W-1:0]   discarded
);

  a_held_beat_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result beat is stalled");

  a_no_msg_unless_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cmrq_pkg::STAT_OK) |->
      (out_id == '0) && (out_len == '0) && (out_payload == '0))
    else $error("message fields set on non-ok result");

  a_nocap_no_discard: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cmrq_pkg::STAT_NOCAP) |-> discarded == '0)
    else $error("zero-capacity result reports discards");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id) &&
      $stable(discarded))
    else $error("stalled result beat changed");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind can_message_ring_queue_unit cmrq_chk u_cmrq_chk (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .out_id      (out_id),
  .out_len     (out_len),
  .out_payload (out_payload),
  .discarded   (discarded)
);

// ----- tb/sv/tb_can_message_ring_queue_unit.sv -----
`timescale 1ns / 100ps

module tb_can_message_ring_queue_unit;
  import cmrq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int SETTLE     = 8;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_PHASE = 4;
  localparam int MAX_PRINTS = 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
    logic [TS_W-1:0]   ts;
    logic [DISC_W-1:0] disc;
  } beat_t;

  typedef struct packed {
    logic  typed;
    beat_t exp;
  } preset_t;

  typedef struct packed {
    logic              cfg;
    logic [CAP_W-1:0]  cap;
    logic [LIM_W-1:0]  lim;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
    logic [TS_W-1:0]   ts;
    logic [NOW_W-1:0]  now;
    logic              typed;
    beat_t             exp;
  } row_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic [LIM_W-1:0] lim;
    int               items;
    int               enq_pct;
  } phase_t;

  localparam beat_t ANS_OK     = '{STAT_OK, '0, '0, '0, '0, '0};
  localparam beat_t ANS_EMPTY  = '{STAT_EMPTY, '0, '0, '0, '0, '0};
  localparam beat_t ANS_NOCAP  = '{STAT_NOCAP, '0, '0, '0, '0, '0};
  localparam beat_t ANS_MAXMSG = '{STAT_OK, '1, 4'd8, '1, '1, '0};
  localparam beat_t ANS_STALE2 = '{STAT_EMPTY, '0, '0, '0, '0, 7'd2};
  localparam beat_t ANS_NONE   = '0;

  localparam int PLAN_LEN = 25;
  localparam row_t PLAN [PLAN_LEN] = '{
    // reset state: cap 64, no age limit
    '{1'b0, 7'd0, 32'd0, OP_PEEK, '0, '0, '0, '0, '0, 1'b1, ANS_EMPTY},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, '1, 1'b1, ANS_EMPTY},
    '{1'b0, 7'd0, 32'd0, OP_UNUSED, '1, '1, '1, '1, '1, 1'b1, ANS_EMPTY},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, '1, 4'd8, '1, '1, '0, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, '0, '0, '0, '0, '1, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_PEEK, '0, '0, '0, '0, '0, 1'b1, ANS_MAXMSG},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, '1, 1'b1, ANS_MAXMSG},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, '0, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'h0AAA_AAAA, 4'd15, 64'h5555_5555_5555_5555,
      32'hA5A5_5A5A, '0, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_PEEK, '0, '0, '0, '0, '0, 1'b0, ANS_NONE},
    // no storage
    '{1'b1, 7'd0, 32'd0, OP_ENQ, 29'd5, 4'd2, 64'h1234, 32'd7, '0, 1'b1, ANS_NOCAP},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, '0, 1'b1, ANS_EMPTY},
    '{1'b0, 7'd0, 32'd0, OP_PEEK, '0, '0, '0, '0, '0, 1'b1, ANS_EMPTY},
    // cap 3: wrap with read ptr at 1, then wrap with read ptr at 0
    '{1'b1, 7'd3, 32'd0, OP_ENQ, 29'd1, 4'd1, 64'h11, 32'd1, '0, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd2, 4'd2, 64'h2222, 32'd2, '0, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd3, 4'd3, 64'h33_3333, 32'd3, '0, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, 32'd4, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd4, 4'd4, 64'h4444_4444, 32'd4, '0, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd5, 4'd5, 64'h55_5555_5555, 32'd5, '0, 1'b0, ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd6, 4'd6, 64'h6666_6666_6666, 32'd6, '0, 1'b0,
      ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd7, 4'd7, 64'h77_7777_7777_7777, 32'd7, '0, 1'b0,
      ANS_NONE},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, 32'd8, 1'b0, ANS_NONE},
    // cap above depth, short age limit: everything goes stale
    '{1'b1, 7'd127, 32'd5, OP_ENQ, 29'd11, 4'd1, 64'hFF, 32'd100, '0, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_ENQ, 29'd12, 4'd1, 64'hEE, 32'd101, '0, 1'b1, ANS_OK},
    '{1'b0, 7'd0, 32'd0, OP_DEQ, '0, '0, '0, '0, 32'd200, 1'b1, ANS_STALE2}
  };

  localparam int N_PHASES = 10;
  localparam phase_t PHASES [N_PHASES] = '{
    '{7'd64,  32'd0,         60,  50},
    '{7'd1,   32'd0,         50,  50},
    '{7'd2,   32'd20,        60,  55},
    '{7'd3,   32'd0,         60,  55},
    '{7'd5,   32'd10,        80,  60},
    '{7'd8,   32'hFFFF_FFFF, 60,  60},
    '{7'd0,   32'd0,         20,  40},
    '{7'd127, 32'd50,        80,  65},
    '{7'd4,   32'd1,         70,  55},
    '{7'd64,  32'd100,       60,  85}
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     opcode;
  logic [ID_W-1:0]     msg_id;
  logic [LEN_W-1:0]    msg_len;
  logic [PAY_W-1:0]    msg_payload;
  logic [TS_W-1:0]     msg_timestamp;
  logic [NOW_W-1:0]    now_ms;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     out_id;
  logic [LEN_W-1:0]    out_len;
  logic [PAY_W-1:0]    out_payload;
  logic [TS_W-1:0]     out_timestamp;
  logic [DISC_W-1:0]   discarded;

  logic                hold_req;
  int                  err_count;
  int                  answer_cnt;

  // queue model state
  logic [CAP_W-1:0]    cap_reg;
  logic [LIM_W-1:0]    lim_reg;
  int unsigned         rd_ptr;
  int unsigned         wr_ptr;
  logic [ID_W-1:0]     slot_id  [DEPTH];
  logic [LEN_W-1:0]    slot_len [DEPTH];
  logic [PAY_W-1:0]    slot_pay [DEPTH];
  logic [TS_W-1:0]     slot_ts  [DEPTH];

  beat_t               answers_due [$];
  preset_t             preset_q [$];

  can_message_ring_queue_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("can_message_ring_queue_unit test failed");
    $finish;
  end

  function automatic logic [PADDR_W-1:0] reg_addr(input reg_idx_t r);
    return PADDR_W'(r) << 2;
  endfunction

  function automatic int unsigned ring_fill(input int unsigned c);
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + c - rd_ptr;
  endfunction

  function automatic beat_t ring_step(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                      input logic [LEN_W-1:0] len,
                                      input logic [PAY_W-1:0] pay,
                                      input logic [TS_W-1:0] ts,
                                      input logic [NOW_W-1:0] now);
    beat_t       r;
    int unsigned c, prior, after, idx, dropped;
    logic        wrapped, stale, found;
    logic [31:0] age;
    r = '0;
    c = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (op)
      OP_ENQ: begin
        if (c == 0) begin
          r.status = STAT_NOCAP;
        end else begin
          prior   = ring_fill(c);
          wrapped = (wr_ptr >= c);
          if (wrapped) wr_ptr = 0;
          if (wrapped && rd_ptr == 0) begin
            rd_ptr = (c > 2) ? 2 : 0;
          end else if (rd_ptr == wr_ptr + 1) begin
            rd_ptr = (rd_ptr + 1 >= c) ? 0 : rd_ptr + 1;
          end
          slot_id[wr_ptr]  = id;
          slot_len[wr_ptr] = len;
          slot_pay[wr_ptr] = pay;
          slot_ts[wr_ptr]  = ts;
          wr_ptr++;
          after    = ring_fill(c);
          r.status = STAT_OK;
          r.disc   = (prior + 1 >= after) ? DISC_W'(prior + 1 - after) : '0;
        end
      end
      OP_DEQ: begin
        dropped = 0;
        found   = 1'b0;
        while (!found && c != 0 && rd_ptr != wr_ptr && rd_ptr < DEPTH) begin
          idx   = rd_ptr;
          age   = now - slot_ts[idx];
          stale = (lim_reg != 0) && (age > lim_reg);
          rd_ptr++;
          if (rd_ptr >= c) begin
            rd_ptr = 0;
            if (wr_ptr >= c) wr_ptr = 0;
          end
          if (stale) begin
            dropped++;
          end else begin
            found = 1'b1;
            r.id  = slot_id[idx];
            r.len = slot_len[idx];
            r.pay = slot_pay[idx];
            r.ts  = slot_ts[idx];
          end
        end
        r.status = found ? STAT_OK : STAT_EMPTY;
        r.disc   = (dropped > 127) ? 7'd127 : DISC_W'(dropped);
      end
      OP_PEEK: begin
        if (c == 0 || rd_ptr == wr_ptr || rd_ptr >= DEPTH) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status = STAT_OK;
          r.id     = slot_id[rd_ptr];
          r.len    = slot_len[rd_ptr];
          r.pay    = slot_pay[rd_ptr];
          r.ts     = slot_ts[rd_ptr];
        end
      end
      default: r.status = STAT_EMPTY;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      if (err_count < MAX_PRINTS)
        $display("beat %0d: %s got %h expected %h", answer_cnt, what, got, want);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    beat_t   want;
    preset_t ps;
    if (rst) begin
      cap_reg    = CAP_RESET;
      lim_reg    = '0;
      rd_ptr     = 0;
      wr_ptr     = 0;
      answer_cnt = 0;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == reg_addr(REG_CAPACITY)) begin
          cap_reg = pwdata[CAP_W-1:0];
          rd_ptr  = 0;
          wr_ptr  = 0;
        end else if (paddr == reg_addr(REG_LATENCY)) begin
          lim_reg = pwdata[LIM_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        want = ring_step(opcode, msg_id, msg_len, msg_payload, msg_timestamp, now_ms);
        if (preset_q.size() != 0) begin
          ps = preset_q.pop_front();
          if (ps.typed) want = ps.exp;
        end
        answers_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          check_field("unexpected beat, status", 64'(status), 'x);
        end else begin
          want = answers_due.pop_front();
          check_field("status", 64'(status), 64'(want.status));
          check_field("out_id", 64'(out_id), 64'(want.id));
          check_field("out_len", 64'(out_len), 64'(want.len));
          check_field("out_payload", out_payload, want.pay);
          check_field("out_timestamp", 64'(out_timestamp), 64'(want.ts));
          check_field("discarded", 64'(discarded), 64'(want.disc));
        end
        answer_cnt++;
      end
    end
  end

  // receiver: stall segments of varying density, plus one long hold on request
  initial begin : receiver
    int unsigned seg, pct;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 30;
        2:       pct = 60;
        default: pct = 90;
      endcase
      repeat (seg) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                       input logic [LEN_W-1:0] len, input logic [PAY_W-1:0] pay,
                       input logic [TS_W-1:0] ts, input logic [NOW_W-1:0] now,
                       input logic typed, input beat_t exp);
    in_valid      <= 1'b1;
    opcode        <= op;
    msg_id        <= id;
    msg_len       <= len;
    msg_payload   <= pay;
    msg_timestamp <= ts;
    now_ms        <= now;
    preset_q.push_back('{typed, exp});
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t r, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(r);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reprogram(input logic [CAP_W-1:0] cap, input logic [LIM_W-1:0] lim);
    logic [PDATA_W-1:0] rb;
    drain();
    apb_access(1'b1, REG_CAPACITY, PDATA_W'(cap), rb);
    apb_access(1'b1, REG_LATENCY, lim, rb);
    apb_access(1'b0, REG_CAPACITY, '0, rb);
    check_field("capacity readback", 64'(rb), 64'(cap));
    apb_access(1'b0, REG_LATENCY, '0, rb);
    check_field("latency_limit readback", 64'(rb), 64'(lim));
  endtask

  task automatic run_phase(input phase_t ph);
    int unsigned     left, burst, pick, gap;
    logic [OP_W-1:0] op;
    logic [31:0]     clock_ms, step_max;
    logic [TS_W-1:0] ts;
    logic [NOW_W-1:0] now;
    step_max = (ph.lim == 0) ? '1 : ph.lim / 3 + 1;
    clock_ms = $urandom;
    left     = ph.items;
    while (left != 0) begin
      burst = $urandom_range(1, 12);
      while (burst != 0 && left != 0) begin
        clock_ms += $urandom_range(0, step_max);
        pick = $urandom_range(0, 99);
        if (pick < ph.enq_pct)   op = OP_ENQ;
        else if (pick >= 97)     op = OP_UNUSED;
        else if (pick % 3 != 0)  op = OP_DEQ;
        else                     op = OP_PEEK;
        ts  = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        offer(op, ID_W'($urandom), LEN_W'($urandom_range(0, 8)), {$urandom, $urandom},
              ts, now, 1'b0, ANS_NONE);
        burst--;
        left--;
      end
      if (left != 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin : stimulus
    err_count     = 0;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    opcode        <= OP_ENQ;
    msg_id        <= '0;
    msg_len       <= '0;
    msg_payload   <= '0;
    msg_timestamp <= '0;
    now_ms        <= '0;
    hold_req      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].cfg) reprogram(PLAN[i].cap, PLAN[i].lim);
      offer(PLAN[i].op, PLAN[i].id, PLAN[i].len, PLAN[i].pay, PLAN[i].ts, PLAN[i].now,
            PLAN[i].typed, PLAN[i].exp);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      reprogram(PHASES[p].cap, PHASES[p].lim);
      if (p == HOLD_PHASE) hold_req <= 1'b1;
      run_phase(PHASES[p]);
    end

    drain();
    if (err_count == 0) begin
      $display("can_message_ring_queue_unit test passed");
    end else begin
      $display("can_message_ring_queue_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cmrq_pkg.sv
rtl/core/cmrq_ram.sv
rtl/core/can_message_ring_queue_unit.sv
rtl/core/cmrq_chk.sv
tb/sv/tb_can_message_ring_queue_unit.sv
